@@ rtl/vdsc_pkg.sv @@
`timescale 1ns / 1ps

package vdsc_pkg;

    typedef enum logic [2:0] {
        MODE_INIT        = 3'd0,
        MODE_IDLE        = 3'd1,
        MODE_PRECHARGE   = 3'd2,
        MODE_SETUP       = 3'd3,
        MODE_SOUND       = 3'd4,
        MODE_DRIVE       = 3'd5,
        MODE_OVERCURRENT = 3'd6,
        MODE_RETURN      = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        CFG_RESUME_LEVEL     = 3'd0,
        CFG_PRESS_LEVEL      = 3'd1,
        CFG_SOUND_TICK_LIMIT = 3'd2,
        CFG_SOUND_REPEATS    = 3'd3,
        CFG_SEND_PERIOD      = 3'd4
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Bit positions in the control flag word.
    localparam int FLAG_LED   = 0;
    localparam int FLAG_TSEL  = 1;
    localparam int FLAG_COOL  = 2;
    localparam int FLAG_SPARE = 3;

    localparam logic [7:0] RESUME_LEVEL_RST     = 8'h26;
    localparam logic [7:0] PRESS_LEVEL_RST      = 8'h50;
    localparam logic [3:0] SOUND_TICK_LIMIT_RST = 4'd10;
    localparam logic [3:0] SOUND_REPEATS_RST    = 4'd10;
    localparam logic [3:0] SEND_PERIOD_RST      = 4'd10;

    typedef struct packed {
        logic [7:0] resume_level;
        logic [7:0] press_level;
        logic [3:0] sound_tick_limit;
        logic [3:0] sound_repeats;
        logic [3:0] send_period;
    } cfg_t;

    typedef struct packed {
        logic        safety_loop;
        logic        brake_pressed;
        logic        drive_button;
        logic        throttle_fault;
        logic        motor_ready;
        logic        overcurrent;
        logic [11:0] throttle_raw;
        logic        send_tick;
        logic        sound_tick;
    } sample_t;

    typedef struct packed {
        logic [2:0] state_code;
        logic       drive_led;
        logic       throttle_select;
        logic       cooling_relay;
        logic       spare_led;
        logic       buzzer_on;
        logic       send_frame;
        logic       heartbeat;
    } result_t;

endpackage

@@ rtl/vehicle_drive_state_controller.sv @@
`timescale 1ns / 1ps
// Path: an accepted input is held in the input register; the sequencer step then
// writes the result register. Throughput: one item per cycle unless out_ready
// stalls a held result; the sequencer state updates in a single step.
// Reset: asynchronous, active low; sequencer in init, counters and valids cleared,
// configuration registers at their default levels.

module vehicle_drive_state_controller
    import vdsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   safety_loop,
    input  logic                   brake_pressed,
    input  logic                   drive_button,
    input  logic                   throttle_fault,
    input  logic                   motor_ready,
    input  logic                   overcurrent,
    input  logic [11:0]            throttle_raw,
    input  logic                   send_tick,
    input  logic                   sound_tick,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [2:0]             state_code,
    output logic                   drive_led,
    output logic                   throttle_select,
    output logic                   cooling_relay,
    output logic                   spare_led,
    output logic                   buzzer_on,
    output logic                   send_frame,
    output logic                   heartbeat
);

    cfg_t    cfg;
    sample_t sample_reg;
    logic    sample_valid_reg;
    result_t step_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    vdsc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A held sample steps the sequencer once the result register is free.
    assign advance  = sample_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !sample_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sample_valid_reg <= 1'b0;
        else if (in_ready)
            sample_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sample_reg.safety_loop    <= safety_loop;
            sample_reg.brake_pressed  <= brake_pressed;
            sample_reg.drive_button   <= drive_button;
            sample_reg.throttle_fault <= throttle_fault;
            sample_reg.motor_ready    <= motor_ready;
            sample_reg.overcurrent    <= overcurrent;
            sample_reg.throttle_raw   <= throttle_raw;
            sample_reg.send_tick      <= send_tick;
            sample_reg.sound_tick     <= sound_tick;
        end
    end

    vdsc_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .sample  (sample_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (!result_valid_reg || out_ready)
            result_valid_reg <= sample_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= step_result;
    end

    assign out_valid       = result_valid_reg;
    assign state_code      = result_reg.state_code;
    assign drive_led       = result_reg.drive_led;
    assign throttle_select = result_reg.throttle_select;
    assign cooling_relay   = result_reg.cooling_relay;
    assign spare_led       = result_reg.spare_led;
    assign buzzer_on       = result_reg.buzzer_on;
    assign send_frame      = result_reg.send_frame;
    assign heartbeat       = result_reg.heartbeat;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid_reg && result_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while both stages are stalled");

    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("sequencer step did not produce a result");

    a_no_result_without_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg && !sample_valid_reg |=> !result_valid_reg)
        else $error("result appeared without a held sample");

endmodule

@@ rtl/vdsc_cfg_regs.sv @@
`timescale 1ns / 1ps

module vdsc_cfg_regs
    import vdsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resume_level     <= RESUME_LEVEL_RST;
            cfg_reg.press_level      <= PRESS_LEVEL_RST;
            cfg_reg.sound_tick_limit <= SOUND_TICK_LIMIT_RST;
            cfg_reg.sound_repeats    <= SOUND_REPEATS_RST;
            cfg_reg.send_period      <= SEND_PERIOD_RST;
        end
        else if (wr_en)
        begin
            // Writes to indexes beyond the register list are dropped.
            unique case (wr_index)
                CFG_RESUME_LEVEL:     cfg_reg.resume_level     <= wr_data;
                CFG_PRESS_LEVEL:      cfg_reg.press_level      <= wr_data;
                CFG_SOUND_TICK_LIMIT: cfg_reg.sound_tick_limit <= wr_data[3:0];
                CFG_SOUND_REPEATS:    cfg_reg.sound_repeats    <= wr_data[3:0];
                CFG_SEND_PERIOD:      cfg_reg.send_period      <= wr_data[3:0];
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/vdsc_seq.sv @@
`timescale 1ns / 1ps

module vdsc_seq
    import vdsc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  sample_t sample,
    input  cfg_t    cfg,
    output result_t result
);

    mode_t      mode_reg, mode_next;
    logic [3:0] send_count_reg, send_count_next;
    logic [3:0] sound_timer_reg, sound_timer_next;
    logic [3:0] sound_count_reg, sound_count_next;
    logic [3:0] flags_reg, flags_next;
    logic       buzzer_reg, buzzer_next;
    logic       heartbeat_reg, heartbeat_next;

    always_comb
    begin
        logic [7:0] thr;
        logic       pressed;
        logic       above;
        logic       frame;
        logic [3:0] send_inc;
        logic [4:0] timer_inc;

        thr     = sample.throttle_raw[11:4];
        pressed = thr > cfg.press_level;
        above   = thr > cfg.resume_level;
        frame   = 1'b0;

        mode_next        = mode_reg;
        send_count_next  = send_count_reg;
        sound_timer_next = sound_timer_reg;
        sound_count_next = sound_count_reg;
        flags_next       = flags_reg;
        buzzer_next      = buzzer_reg;
        heartbeat_next   = heartbeat_reg;

        send_inc  = send_count_reg + 4'd1;
        timer_inc = {1'b0, sound_timer_reg} + 5'd1;

        if (sample.send_tick)
        begin
            if (send_inc == cfg.send_period)
            begin
                frame           = 1'b1;
                send_count_next = 4'd0;
                heartbeat_next  = ~heartbeat_reg;
            end
            else
            begin
                send_count_next = send_inc;
            end
        end

        unique case (mode_reg)
            MODE_INIT:
            begin
                flags_next = 4'b0000;
                mode_next  = MODE_IDLE;
            end
            MODE_IDLE:
            begin
                flags_next = 4'b0000;
                if (sample.safety_loop)
                    mode_next = MODE_PRECHARGE;
            end
            MODE_PRECHARGE:
            begin
                flags_next = 4'b0000;
                if (!sample.safety_loop)
                    mode_next = MODE_IDLE;
                else if (sample.motor_ready)
                    mode_next = MODE_SETUP;
            end
            MODE_SETUP:
            begin
                flags_next           = 4'b0000;
                flags_next[FLAG_COOL] = 1'b1;
                if (!sample.safety_loop)
                    mode_next = MODE_IDLE;
                else if (sample.drive_button && !sample.throttle_fault
                         && sample.brake_pressed && sample.motor_ready)
                    mode_next = MODE_SOUND;
            end
            MODE_SOUND:
            begin
                buzzer_next = 1'b1;
                if (sample.sound_tick)
                begin
                    // The timer is compared one bit wider so a limit of 15 wraps at 16.
                    if (timer_inc > {1'b0, cfg.sound_tick_limit})
                    begin
                        sound_timer_next = 4'd0;
                        if (sound_count_reg < cfg.sound_repeats)
                            sound_count_next = sound_count_reg + 4'd1;
                    end
                    else
                    begin
                        sound_timer_next = timer_inc[3:0];
                    end
                end
                if (!sample.safety_loop)
                begin
                    buzzer_next = 1'b0;
                    mode_next   = MODE_IDLE;
                end
                else if (sound_count_next >= cfg.sound_repeats)
                begin
                    buzzer_next = 1'b0;
                    if (!sample.drive_button && sample.brake_pressed)
                        mode_next = MODE_DRIVE;
                end
            end
            MODE_DRIVE:
            begin
                sound_count_next       = 4'd0;
                flags_next[FLAG_LED]   = 1'b1;
                flags_next[FLAG_TSEL]  = 1'b1;
                flags_next[FLAG_SPARE] = 1'b1;
                if (!sample.safety_loop)
                    mode_next = MODE_IDLE;
                else if (sample.throttle_fault || (pressed && sample.brake_pressed)
                         || !sample.motor_ready
                         || (sample.drive_button && sample.brake_pressed))
                    mode_next = MODE_RETURN;
                else if (sample.overcurrent)
                    mode_next = MODE_OVERCURRENT;
            end
            MODE_OVERCURRENT:
            begin
                flags_next            = 4'b0000;
                flags_next[FLAG_COOL] = 1'b1;
                if (!sample.safety_loop)
                    mode_next = MODE_IDLE;
                else if (!sample.overcurrent && above)
                    mode_next = MODE_DRIVE;
            end
            MODE_RETURN:
            begin
                // This state does not watch the safety loop.
                if (!sample.drive_button)
                    mode_next = MODE_SETUP;
            end
        endcase

        result.state_code      = mode_reg;
        result.drive_led       = flags_next[FLAG_LED];
        result.throttle_select = flags_next[FLAG_TSEL];
        result.cooling_relay   = flags_next[FLAG_COOL];
        result.spare_led       = flags_next[FLAG_SPARE];
        result.buzzer_on       = buzzer_next;
        result.send_frame      = frame;
        result.heartbeat       = heartbeat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_INIT;
            send_count_reg  <= 4'd0;
            sound_timer_reg <= 4'd0;
            sound_count_reg <= 4'd0;
            flags_reg       <= 4'b0000;
            buzzer_reg      <= 1'b0;
            heartbeat_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg        <= mode_next;
            send_count_reg  <= send_count_next;
            sound_timer_reg <= sound_timer_next;
            sound_count_reg <= sound_count_next;
            flags_reg       <= flags_next;
            buzzer_reg      <= buzzer_next;
            heartbeat_reg   <= heartbeat_next;
        end
    end

    a_init_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && mode_reg == MODE_INIT |=> mode_reg == MODE_IDLE)
        else $error("init state did not move to idle");

    a_hold_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(mode_reg) && $stable(heartbeat_reg) && $stable(send_count_reg))
        else $error("sequencer state changed without a step");

    a_heartbeat_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !result.send_frame |=> $stable(heartbeat_reg))
        else $error("heartbeat toggled without a frame");

    a_buzzer_only_in_sound: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && mode_reg != MODE_SOUND |=> $stable(buzzer_reg))
        else $error("buzzer changed outside the sound state");

endmodule
